[rtl/qou_pkg.sv]
// Shared types, constants and arithmetic helpers for the quaternion orientation update.
package qou_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 64;

    localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [2:0] {
        MODE_LOAD   = 3'd0,
        MODE_INTEG  = 3'd1,
        MODE_ROTATE = 3'd2,
        MODE_NORM   = 3'd3,
        MODE_ADD    = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SVEC,
        S_PROD,
        S_SQ,
        S_ROOT,
        S_DIV,
        S_DONE
    } t_state;

    // One term of the product q * (0, v)
    typedef struct packed {
        logic [1:0] c;     // quaternion component
        logic [1:0] v;     // vector component
        logic       neg;   // subtract this term
        logic       last;  // closes an output component
    } t_term;

    // Handshake between the sequencer and a serial unit
    typedef struct packed {
        logic start;
        logic done;
    } t_unit_hs;

    // Term schedule: three terms per output component, w first
    function automatic t_term term_of(input logic [3:0] idx);
        t_term t;
        t = '0;
        case (idx)
            4'd0:  t = '{c: 2'd1, v: 2'd0, neg: 1'b1, last: 1'b0};
            4'd1:  t = '{c: 2'd2, v: 2'd1, neg: 1'b1, last: 1'b0};
            4'd2:  t = '{c: 2'd3, v: 2'd2, neg: 1'b1, last: 1'b1};
            4'd3:  t = '{c: 2'd0, v: 2'd0, neg: 1'b0, last: 1'b0};
            4'd4:  t = '{c: 2'd2, v: 2'd2, neg: 1'b0, last: 1'b0};
            4'd5:  t = '{c: 2'd3, v: 2'd1, neg: 1'b1, last: 1'b1};
            4'd6:  t = '{c: 2'd0, v: 2'd1, neg: 1'b0, last: 1'b0};
            4'd7:  t = '{c: 2'd3, v: 2'd0, neg: 1'b0, last: 1'b0};
            4'd8:  t = '{c: 2'd1, v: 2'd2, neg: 1'b1, last: 1'b1};
            4'd9:  t = '{c: 2'd0, v: 2'd2, neg: 1'b0, last: 1'b0};
            4'd10: t = '{c: 2'd1, v: 2'd1, neg: 1'b0, last: 1'b0};
            4'd11: t = '{c: 2'd2, v: 2'd0, neg: 1'b1, last: 1'b1};
            default: t = '0;
        endcase
        return t;
    endfunction

    // Arithmetic shift right, rounding half toward plus infinity
    function automatic logic signed [PROD_W-1:0] round_shift(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              s
    );
        logic signed [PROD_W-1:0] bias;
        bias = 64'sd1 <<< (s - 1);
        return (v + bias) >>> s;
    endfunction

    function automatic logic over32(input logic signed [PROD_W-1:0] v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/quaternion_orientation_update.sv]
// Top level: orientation quaternion register, operation sequencer and serial units.
//
// Holds one orientation quaternion (w,x,y,z) in signed fixed point with FRAC_BITS
// fractional bits, reset to identity. Each accepted word applies one operation
// (load, integrate, rotate by vector, normalize, add) and returns the updated
// quaternion with a saturation flag. One word is processed at a time; o_in_stall
// is high from acceptance until the result enters the output register. Load, add
// and unused modes skip the serial units. Every product runs through a bit-serial
// multiplier, so rotate takes 12 products and integrate 15. Normalize takes
// 4 squares, a square root and four divisions. A finished result waits in the
// output register while the next word is accepted.
module quaternion_orientation_update #(
    parameter int unsigned FRAC_BITS = 27
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [2:0]                        i_mode,
    input  logic signed [qou_pkg::DATA_W-1:0] i_operand_w,
    input  logic signed [qou_pkg::DATA_W-1:0] i_operand_x,
    input  logic signed [qou_pkg::DATA_W-1:0] i_operand_y,
    input  logic signed [qou_pkg::DATA_W-1:0] i_operand_z,
    input  logic signed [qou_pkg::DATA_W-1:0] i_scale,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [qou_pkg::DATA_W-1:0] o_out_w,
    output logic signed [qou_pkg::DATA_W-1:0] o_out_x,
    output logic signed [qou_pkg::DATA_W-1:0] o_out_y,
    output logic signed [qou_pkg::DATA_W-1:0] o_out_z,
    output logic                              o_saturated
);
    import qou_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

    t_state                   r_state, n_state;
    t_mode                    r_mode, n_mode;
    logic signed [DATA_W-1:0] r_q   [4];
    logic signed [DATA_W-1:0] n_q   [4];
    logic signed [DATA_W-1:0] r_opd [4];
    logic signed [DATA_W-1:0] n_opd [4];
    logic signed [DATA_W-1:0] r_nxt [4];
    logic signed [DATA_W-1:0] n_nxt [4];
    logic signed [DATA_W-1:0] r_vec [3];
    logic signed [DATA_W-1:0] n_vec [3];
    logic signed [DATA_W-1:0] r_sc, n_sc;
    logic signed [PROD_W-1:0] r_acc, n_acc;
    logic        [PROD_W:0]   r_sum, n_sum;
    logic        [DATA_W-1:0] r_root, n_root;
    logic        [3:0]        r_idx, n_idx;
    logic        [1:0]        r_k, n_k;
    logic                     r_wait, n_wait;
    logic                     r_flag, n_flag;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out [4];
    logic signed [DATA_W-1:0] n_out [4];
    logic                     r_out_sat, n_out_sat;

    logic                     mul_start, mul_done;
    logic                     root_start, root_done;
    logic                     div_start, div_done;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic        [DATA_W-1:0] root_q;
    logic        [PROD_W-1:0] div_num;
    logic        [PROD_W-1:0] div_q;

    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [PROD_W-1:0] term_val;
    logic signed [PROD_W-1:0] acc_sum;
    logic signed [PROD_W-1:0] fin;
    logic        [PROD_W:0]   sq_sum;
    logic        [PROD_W-1:0] norm_sq;
    logic        [DATA_W-1:0] mag;
    logic                     neg;
    logic                     div_ov;
    logic signed [PROD_W-1:0] add_v;
    t_term                    term;

    // Serial arithmetic units
    qou_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    qou_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (r_sum[PROD_W-1:0]),
        .o_done  (root_done),
        .o_root  (root_q)
    );

    qou_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (r_root),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_q         = r_q;
        n_opd       = r_opd;
        n_nxt       = r_nxt;
        n_vec       = r_vec;
        n_sc        = r_sc;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_root      = r_root;
        n_idx       = r_idx;
        n_k         = r_k;
        n_wait      = r_wait;
        n_flag      = r_flag;
        n_out       = r_out;
        n_out_sat   = r_out_sat;
        n_out_valid = r_out_valid && i_out_stall;

        mul_start  = 1'b0;
        root_start = 1'b0;
        div_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;

        term     = term_of(r_idx);
        prod_rnd = round_shift(mul_p, FRAC_BITS);
        term_val = term.neg ? -prod_rnd : prod_rnd;
        acc_sum  = r_acc + term_val;
        fin      = (r_mode == MODE_INTEG)
                 ? (PROD_W'(r_q[r_k]) + round_shift(acc_sum, 1)) : acc_sum;
        sq_sum   = r_sum + {1'b0, mul_p};
        norm_sq  = sq_sum[PROD_W] ? '1 : sq_sum[PROD_W-1:0];
        neg      = r_q[r_idx[1:0]][DATA_W-1];
        mag      = neg ? DATA_W'(-r_q[r_idx[1:0]]) : r_q[r_idx[1:0]];
        div_num  = (PROD_W'(mag) << FRAC_BITS) + PROD_W'(r_root >> 1);
        div_ov   = neg ? (div_q > 64'h0000_0000_8000_0000)
                       : (div_q > 64'h0000_0000_7FFF_FFFF);
        add_v    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = t_mode'(i_mode);
                    n_opd[0] = i_operand_w;
                    n_opd[1] = i_operand_x;
                    n_opd[2] = i_operand_y;
                    n_opd[3] = i_operand_z;
                    n_sc     = i_scale;
                    n_flag   = 1'b0;
                    n_idx    = '0;
                    n_k      = '0;
                    n_wait   = 1'b0;
                    n_acc    = '0;
                    n_sum    = '0;
                    case (t_mode'(i_mode))
                        MODE_LOAD: begin
                            n_nxt[0] = i_operand_w;
                            n_nxt[1] = i_operand_x;
                            n_nxt[2] = i_operand_y;
                            n_nxt[3] = i_operand_z;
                            n_state  = S_DONE;
                        end
                        MODE_ADD: begin
                            add_v    = PROD_W'(r_q[0]) + PROD_W'(i_operand_w);
                            n_nxt[0] = sat32(add_v);
                            n_flag   = over32(add_v);
                            add_v    = PROD_W'(r_q[1]) + PROD_W'(i_operand_x);
                            n_nxt[1] = sat32(add_v);
                            n_flag   = n_flag | over32(add_v);
                            add_v    = PROD_W'(r_q[2]) + PROD_W'(i_operand_y);
                            n_nxt[2] = sat32(add_v);
                            n_flag   = n_flag | over32(add_v);
                            add_v    = PROD_W'(r_q[3]) + PROD_W'(i_operand_z);
                            n_nxt[3] = sat32(add_v);
                            n_flag   = n_flag | over32(add_v);
                            n_state  = S_DONE;
                        end
                        MODE_INTEG: begin
                            n_state = S_SVEC;
                        end
                        MODE_ROTATE: begin
                            n_vec[0] = i_operand_x;
                            n_vec[1] = i_operand_y;
                            n_vec[2] = i_operand_z;
                            n_state  = S_PROD;
                        end
                        MODE_NORM: begin
                            n_state = S_SQ;
                        end
                        default: begin
                            n_nxt   = r_q;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Scale the angular rate vector
            S_SVEC: begin
                mul_a = r_opd[r_idx[1:0] + 2'd1];
                mul_b = r_sc;
                if (!r_wait) begin
                    mul_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (mul_done) begin
                    n_vec[r_idx[1:0]] = sat32(prod_rnd);
                    n_flag            = r_flag | over32(prod_rnd);
                    n_wait            = 1'b0;
                    if (r_idx == 4'd2) begin
                        n_idx   = '0;
                        n_state = S_PROD;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end

            // Accumulate the twelve terms of q * (0, v)
            S_PROD: begin
                mul_a = r_q[term.c];
                mul_b = r_vec[term.v];
                if (!r_wait) begin
                    mul_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (mul_done) begin
                    n_wait = 1'b0;
                    n_idx  = r_idx + 4'd1;
                    if (term.last) begin
                        n_nxt[r_k] = sat32(fin);
                        n_flag     = r_flag | over32(fin);
                        n_acc      = '0;
                        n_k        = r_k + 2'd1;
                        if (r_idx == 4'd11) begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_acc = acc_sum;
                    end
                end
            end

            // Sum the squared components
            S_SQ: begin
                mul_a = r_q[r_idx[1:0]];
                mul_b = r_q[r_idx[1:0]];
                if (!r_wait) begin
                    mul_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (mul_done) begin
                    n_wait = 1'b0;
                    if (r_idx == 4'd3) begin
                        n_idx = '0;
                        n_sum = {1'b0, norm_sq};
                        if (norm_sq == '0) begin
                            n_nxt[0] = ONE;
                            n_nxt[1] = '0;
                            n_nxt[2] = '0;
                            n_nxt[3] = '0;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_ROOT;
                        end
                    end else begin
                        n_sum = sq_sum;
                        n_idx = r_idx + 4'd1;
                    end
                end
            end

            S_ROOT: begin
                if (!r_wait) begin
                    root_start = 1'b1;
                    n_wait     = 1'b1;
                end else if (root_done) begin
                    n_root  = root_q;
                    n_wait  = 1'b0;
                    n_state = S_DIV;
                end
            end

            // Divide each magnitude by the norm, rounded
            S_DIV: begin
                if (!r_wait) begin
                    div_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (div_done) begin
                    n_wait = 1'b0;
                    if (div_ov) begin
                        n_nxt[r_idx[1:0]] = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end else begin
                        n_nxt[r_idx[1:0]] = neg ? DATA_W'(-div_q[DATA_W-1:0])
                                                : div_q[DATA_W-1:0];
                    end
                    n_flag = r_flag | div_ov;
                    if (r_idx == 4'd3) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end

            // Commit and hand the word to the output register
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_q         = r_nxt;
                    n_out       = r_nxt;
                    n_out_sat   = r_flag;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wait      <= 1'b0;
            r_idx       <= '0;
            r_k         <= '0;
            r_q[0]      <= ONE;
            r_q[1]      <= '0;
            r_q[2]      <= '0;
            r_q[3]      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_wait      <= n_wait;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_q         <= n_q;
        end
        r_mode    <= n_mode;
        r_opd     <= n_opd;
        r_nxt     <= n_nxt;
        r_vec     <= n_vec;
        r_sc      <= n_sc;
        r_acc     <= n_acc;
        r_sum     <= n_sum;
        r_root    <= n_root;
        r_flag    <= n_flag;
        r_out     <= n_out;
        r_out_sat <= n_out_sat;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_w     = r_out[0];
    assign o_out_x     = r_out[1];
    assign o_out_y     = r_out[2];
    assign o_out_z     = r_out[3];
    assign o_saturated = r_out_sat;

endmodule

[rtl/qou_mul.sv]
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
module qou_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [qou_pkg::DATA_W-1:0]     i_a,
    input  logic signed [qou_pkg::DATA_W-1:0]     i_b,
    output logic                                  o_done,
    output logic signed [qou_pkg::PROD_W-1:0]     o_product
);
    import qou_pkg::*;

    logic signed [PROD_W-1:0] r_mcand, n_mcand;
    logic        [DATA_W-1:0] r_mplier, n_mplier;
    logic signed [PROD_W-1:0] r_acc, n_acc;
    logic        [4:0]        r_cnt, n_cnt;
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic signed [PROD_W-1:0] addend;

    // Add one partial product; the sign bit weighs negative
    always_comb begin
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        addend   = r_mplier[0] ? r_mcand : '0;
        if (i_start) begin
            n_mcand  = PROD_W'(i_a);
            n_mplier = i_b;
            n_acc    = '0;
            n_cnt    = '0;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            n_acc    = (r_cnt == 5'd31) ? (r_acc - addend) : (r_acc + addend);
            n_mcand  = r_mcand <<< 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

[rtl/qou_root.sv]
// Digit-serial integer square root of a 64-bit value, two radicand bits per cycle.
module qou_root (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [qou_pkg::PROD_W-1:0]        i_value,
    output logic                              o_done,
    output logic [qou_pkg::DATA_W-1:0]        o_root
);
    import qou_pkg::*;

    logic [PROD_W-1:0] r_val, n_val;
    logic [33:0]       r_rem, n_rem;
    logic [DATA_W-1:0] r_root, n_root;
    logic [4:0]        r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [35:0]       rem_s;
    logic [35:0]       trial;

    // Bring down two bits, try root*4+1
    always_comb begin
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        rem_s  = {r_rem, r_val[PROD_W-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        if (i_start) begin
            n_val  = i_value;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = r_val << 2;
            if (rem_s >= trial) begin
                n_rem  = 34'(rem_s - trial);
                n_root = {r_root[DATA_W-2:0], 1'b1};
            end else begin
                n_rem  = 34'(rem_s);
                n_root = {r_root[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[rtl/qou_div.sv]
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
module qou_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [qou_pkg::PROD_W-1:0]        i_dividend,
    input  logic [qou_pkg::DATA_W-1:0]        i_divisor,
    output logic                              o_done,
    output logic [qou_pkg::PROD_W-1:0]        o_quotient
);
    import qou_pkg::*;

    logic [PROD_W-1:0] r_num, n_num;
    logic [DATA_W-1:0] r_den, n_den;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [PROD_W-1:0] r_quo, n_quo;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DATA_W:0]   rem_s;

    // Shift in one dividend bit, subtract when it fits
    always_comb begin
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        rem_s  = {r_rem, r_num[PROD_W-1]};
        if (i_start) begin
            n_num  = i_dividend;
            n_den  = i_divisor;
            n_rem  = '0;
            n_quo  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = r_num << 1;
            if (rem_s >= {1'b0, r_den}) begin
                n_rem = DATA_W'(rem_s - {1'b0, r_den});
                n_quo = {r_quo[PROD_W-2:0], 1'b1};
            end else begin
                n_rem = rem_s[DATA_W-1:0];
                n_quo = {r_quo[PROD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/qou_checker.sv]
// Port-level checks for the quaternion orientation update, bound to the top level.
module qou_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_out_w,
    input logic        o_saturated
);

    // No result word survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An accepted word makes the input side busy in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // A new result appears only at the end of a word's processing
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without processing");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_w)
                                          && $stable(o_saturated)))
        else $error("stalled result changed");

endmodule

bind quaternion_orientation_update qou_checker u_qou_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_w     (o_out_w),
    .o_saturated (o_saturated)
);
